FILE: rtl/lpht_pkg.sv
package lpht_pkg;

    // Field widths
    localparam int OPCODE_W = 2;
    localparam int KEY_W    = 31;
    localparam int STATUS_W = 3;
    localparam int POS_W    = 4;
    localparam int TAG_W    = 2;
    localparam int ENTRY_W  = TAG_W + KEY_W;

    // Remainder unit: key taken apart in 4-bit digits, most significant first
    localparam int DIGIT_W    = 4;
    localparam int KEY_DIGITS = 8;

    // Request codes
    localparam logic [OPCODE_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_SEARCH = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_DELETE = 2'd2;
    localparam logic [OPCODE_W-1:0] OP_NONE   = 2'd3;

    // Result codes
    localparam logic [STATUS_W-1:0] ST_INSERTED = 3'd0;
    localparam logic [STATUS_W-1:0] ST_FULL     = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FOUND    = 3'd2;
    localparam logic [STATUS_W-1:0] ST_MISSING  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_DELETED  = 3'd4;

    // Slot tags
    localparam logic [TAG_W-1:0] TAG_EMPTY = 2'd0;
    localparam logic [TAG_W-1:0] TAG_USED  = 2'd1;
    localparam logic [TAG_W-1:0] TAG_TOMB  = 2'd2;

endpackage

FILE: rtl/linear_probe_hash_table_top.sv
// Channel   Handshake              Payload            Item
// request   req_valid / req_ready  opcode, key        one insert, search or delete
// response  rsp_valid / rsp_ready  status, position   one result per request
//
// A request runs from acceptance through the 4-bit-per-step remainder unit, the
// home read issue and one probe per cycle through the single-read-port slot
// memory (P probes, P from 1 to TABLE_SLOTS) to the posting of the result;
// the next request is then taken in the idle state.
// After reset a clearing pass marks every slot empty.
// The finished result sits in an output register, so the next request is taken
// while it waits; a stalled response only holds the following result.
module linear_probe_hash_table_top
    import lpht_pkg::*;
#(
    parameter int TABLE_SLOTS = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_ready,
    input  logic [OPCODE_W-1:0] opcode,
    input  logic [KEY_W-1:0]    key,
    output logic                rsp_valid,
    input  logic                rsp_ready,
    output logic [STATUS_W-1:0] status,
    output logic [POS_W-1:0]    position
);

    localparam int AW = $clog2(TABLE_SLOTS);
    localparam logic [AW-1:0] SLOT_LAST = AW'(TABLE_SLOTS - 1);

    typedef enum logic [4:0] {
        ST_CLEAR = 5'b00001,
        ST_IDLE  = 5'b00010,
        ST_MOD   = 5'b00100,
        ST_PROBE = 5'b01000,
        ST_HOLD  = 5'b10000
    } state_t;

    state_t                state_reg, state_next;
    logic [AW-1:0]         clr_reg, clr_next;
    logic [AW-1:0]         cur_reg, cur_next;
    logic [AW-1:0]         issue_reg, issue_next;
    logic [AW-1:0]         cnt_reg, cnt_next;
    logic [OPCODE_W-1:0]   op_reg, op_next;
    logic [KEY_W-1:0]      key_reg, key_next;
    logic [STATUS_W-1:0]   res_status_reg, res_status_next;
    logic [POS_W-1:0]      res_pos_reg, res_pos_next;
    logic                  rsp_valid_reg, rsp_valid_next;
    logic [STATUS_W-1:0]   rsp_status_reg, rsp_status_next;
    logic [POS_W-1:0]      rsp_pos_reg, rsp_pos_next;

    logic                  ram_we;
    logic [AW-1:0]         ram_waddr;
    logic [ENTRY_W-1:0]    ram_wdata;
    logic [AW-1:0]         ram_raddr;
    logic [ENTRY_W-1:0]    ram_rdata;
    logic [TAG_W-1:0]      rd_tag;
    logic [KEY_W-1:0]      rd_key;

    logic                  mod_start;
    logic                  mod_done;
    logic [AW-1:0]         mod_rem;
    logic                  finish;

    function automatic logic [AW-1:0] slot_after(input logic [AW-1:0] s);
        return (s == SLOT_LAST) ? '0 : s + 1'b1;
    endfunction

    lpht_mod #(
        .SLOTS(TABLE_SLOTS)
    ) u_mod (
        .clk  (clk),
        .rst_n(rst_n),
        .start(mod_start),
        .key  (key),
        .done (mod_done),
        .rem  (mod_rem)
    );

    lpht_ram #(
        .WIDTH(ENTRY_W),
        .DEPTH(TABLE_SLOTS)
    ) u_slots (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    assign rd_tag    = ram_rdata[ENTRY_W-1 -: TAG_W];
    assign rd_key    = ram_rdata[KEY_W-1:0];
    assign req_ready = (state_reg == ST_IDLE);
    assign mod_start = req_valid && req_ready && (opcode != OP_NONE);

    // Sequence clearing, remainder, probing and result hand-off
    always_comb
    begin
        state_next      = state_reg;
        clr_next        = clr_reg;
        cur_next        = cur_reg;
        issue_next      = issue_reg;
        cnt_next        = cnt_reg;
        op_next         = op_reg;
        key_next        = key_reg;
        res_status_next = res_status_reg;
        res_pos_next    = res_pos_reg;
        rsp_valid_next  = rsp_valid_reg && !rsp_ready;
        rsp_status_next = rsp_status_reg;
        rsp_pos_next    = rsp_pos_reg;
        ram_we          = 1'b0;
        ram_waddr       = cur_reg;
        ram_wdata       = {TAG_EMPTY, KEY_W'(0)};
        ram_raddr       = issue_reg;
        finish          = 1'b0;

        case (state_reg)
            ST_CLEAR:
            begin
                // Sweep every slot to empty
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                if (clr_reg == SLOT_LAST)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    clr_next = clr_reg + 1'b1;
                end
            end

            ST_IDLE:
            begin
                // Take the item; drop the unused code without a result
                if (req_valid)
                begin
                    op_next  = opcode;
                    key_next = key;
                    if (opcode != OP_NONE)
                    begin
                        state_next = ST_MOD;
                    end
                end
            end

            ST_MOD:
            begin
                // Issue the home slot read once the remainder is ready
                ram_raddr = mod_rem;
                if (mod_done)
                begin
                    cur_next   = mod_rem;
                    issue_next = slot_after(mod_rem);
                    cnt_next   = '0;
                    state_next = ST_PROBE;
                end
            end

            ST_PROBE:
            begin
                // Read ahead the following slot while checking the current one
                cur_next   = issue_reg;
                issue_next = slot_after(issue_reg);
                cnt_next   = cnt_reg + 1'b1;
                case (op_reg)
                    OP_INSERT:
                    begin
                        if (rd_tag != TAG_USED)
                        begin
                            ram_we          = 1'b1;
                            ram_wdata       = {TAG_USED, key_reg};
                            res_status_next = ST_INSERTED;
                            res_pos_next    = POS_W'(cur_reg);
                            finish          = 1'b1;
                        end
                        else if (cnt_reg == SLOT_LAST)
                        begin
                            res_status_next = ST_FULL;
                            res_pos_next    = '0;
                            finish          = 1'b1;
                        end
                    end
                    OP_SEARCH, OP_DELETE:
                    begin
                        if ((rd_tag == TAG_USED) && (rd_key == key_reg))
                        begin
                            res_pos_next = POS_W'(cur_reg);
                            if (op_reg == OP_DELETE)
                            begin
                                ram_we          = 1'b1;
                                ram_wdata       = {TAG_TOMB, rd_key};
                                res_status_next = ST_DELETED;
                            end
                            else
                            begin
                                res_status_next = ST_FOUND;
                            end
                            finish = 1'b1;
                        end
                        else if ((rd_tag == TAG_EMPTY) || (cnt_reg == SLOT_LAST))
                        begin
                            res_status_next = ST_MISSING;
                            res_pos_next    = '0;
                            finish          = 1'b1;
                        end
                    end
                    default:
                    begin
                        res_status_next = ST_MISSING;
                        res_pos_next    = '0;
                        finish          = 1'b1;
                    end
                endcase
                if (finish)
                begin
                    state_next = ST_HOLD;
                end
            end

            ST_HOLD:
            begin
                // Hand the result over once the output register is free
                if (!rsp_valid_reg || rsp_ready)
                begin
                    rsp_valid_next  = 1'b1;
                    rsp_status_next = res_status_reg;
                    rsp_pos_next    = res_pos_reg;
                    state_next      = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            cnt_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            cnt_reg       <= cnt_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        cur_reg        <= cur_next;
        issue_reg      <= issue_next;
        op_reg         <= op_next;
        key_reg        <= key_next;
        res_status_reg <= res_status_next;
        res_pos_reg    <= res_pos_next;
        rsp_status_reg <= rsp_status_next;
        rsp_pos_reg    <= rsp_pos_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign status    = rsp_status_reg;
    assign position  = rsp_pos_reg;

    // The remainder unit reports only while a request waits for its home slot
    assert property (@(posedge clk) disable iff (!rst_n)
        mod_done |-> (state_reg == ST_MOD))
        else $error("remainder done outside home slot wait");

    // A probe never runs past one full lap
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_PROBE) |-> (cnt_reg <= SLOT_LAST))
        else $error("probe count beyond table size");

    // A slot write during probing ends the probe
    assert property (@(posedge clk) disable iff (!rst_n)
        (ram_we && (state_reg == ST_PROBE)) |=> (state_reg == ST_HOLD))
        else $error("probe continued after slot write");

    // Only defined result codes leave the block
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (status <= ST_DELETED))
        else $error("undefined result code");

endmodule

FILE: rtl/lpht_ram.sv
module lpht_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write one entry, read one entry with registered data
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: rtl/lpht_mod.sv
module lpht_mod
    import lpht_pkg::*;
#(
    parameter int SLOTS = 16
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic [KEY_W-1:0]         key,
    output logic                     done,
    output logic [$clog2(SLOTS)-1:0] rem
);

    localparam int AW  = $clog2(SLOTS);
    localparam int PW  = AW + DIGIT_W;
    localparam int SHW = KEY_DIGITS * DIGIT_W;
    localparam int SW  = $clog2(KEY_DIGITS);
    localparam logic [SW-1:0] STEP_LAST = SW'(KEY_DIGITS - 1);

    logic           busy_reg;
    logic           done_reg;
    logic [SW-1:0]  step_reg;
    logic [SHW-1:0] shift_reg;
    logic [AW-1:0]  rem_reg;

    logic [PW-1:0]  part;
    logic [PW-1:0]  sub;
    logic [AW-1:0]  rem_step;

    // Append the next digit and pull the partial value back below SLOTS
    always_comb
    begin
        part = {rem_reg, shift_reg[SHW-1 -: DIGIT_W]};
        sub  = '0;
        for (int k = 1; k < (1 << DIGIT_W); k++)
        begin
            if (part >= PW'(k * SLOTS))
            begin
                sub = PW'(k * SLOTS);
            end
        end
        rem_step = AW'(part - sub);
    end

    // Step through the key one digit per cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            step_reg  <= '0;
            shift_reg <= '0;
            rem_reg   <= '0;
        end
        else if (start)
        begin
            busy_reg  <= 1'b1;
            done_reg  <= 1'b0;
            step_reg  <= '0;
            shift_reg <= SHW'(key);
            rem_reg   <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg   <= rem_step;
            shift_reg <= shift_reg << DIGIT_W;
            step_reg  <= step_reg + 1'b1;
            if (step_reg == STEP_LAST)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    assign done = done_reg;
    assign rem  = rem_reg;

endmodule

FILE: tb/lpht_result_checker.sv
`timescale 1ns / 100ps

// Watches both channels of the hash table, keeps its own copy of the slot
// array, predicts one answer per accepted request but the unused code, and compares answers in order.
module lpht_result_checker
    import lpht_pkg::*;
#(
    parameter int TABLE_SLOTS = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    input  logic                req_ready,
    input  logic [OPCODE_W-1:0] opcode,
    input  logic [KEY_W-1:0]    key,
    input  logic                rsp_valid,
    input  logic                rsp_ready,
    input  logic [STATUS_W-1:0] status,
    input  logic [POS_W-1:0]    position,
    output int                  mismatch_count,
    output int                  pending_count,
    output int                  answers_checked
);

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [POS_W-1:0]    position;
    } table_answer_t;

    // Shadow copy of the table
    logic [KEY_W-1:0] shadow_key [TABLE_SLOTS];
    logic [TAG_W-1:0] shadow_tag [TABLE_SLOTS];

    table_answer_t pending_answers [$];

    int errors  = 0;
    int waiting = 0;
    int checked = 0;

    assign mismatch_count  = errors;
    assign pending_count   = waiting;
    assign answers_checked = checked;

    // Print the first few mismatches, count all of them
    task automatic report_mismatch(input string what);
        if (errors < 20)
            $display("[%0t] mismatch: %s", $realtime, what);
        errors++;
    endtask

    // Find the slot holding k; stop at a never-used slot or after one lap
    function automatic bit locate_key(input logic [KEY_W-1:0] k, output int where);
        int s;
        s = int'(k % TABLE_SLOTS);
        where = 0;
        for (int n = 0; n < TABLE_SLOTS; n++)
        begin
            if (shadow_tag[s] == TAG_USED && shadow_key[s] == k)
            begin
                where = s;
                return 1'b1;
            end
            if (shadow_tag[s] == TAG_EMPTY)
                return 1'b0;
            s = (s + 1 >= TABLE_SLOTS) ? 0 : s + 1;
        end
        return 1'b0;
    endfunction

    // Apply one request to the shadow table and return its answer
    function automatic table_answer_t apply_request(input logic [OPCODE_W-1:0] op,
                                                    input logic [KEY_W-1:0] k);
        table_answer_t ans;
        int            s;
        int            hit;
        ans.position = '0;
        if (op == OP_INSERT)
        begin
            ans.status = ST_FULL;
            s = int'(k % TABLE_SLOTS);
            for (int n = 0; n < TABLE_SLOTS; n++)
            begin
                if (shadow_tag[s] != TAG_USED)
                begin
                    shadow_key[s] = k;
                    shadow_tag[s] = TAG_USED;
                    ans.status    = ST_INSERTED;
                    ans.position  = s[POS_W-1:0];
                    break;
                end
                s = (s + 1 >= TABLE_SLOTS) ? 0 : s + 1;
            end
        end
        else if (locate_key(k, hit))
        begin
            if (op == OP_DELETE)
            begin
                shadow_tag[hit] = TAG_TOMB;
                ans.status = ST_DELETED;
            end
            else
            begin
                ans.status = ST_FOUND;
            end
            ans.position = hit[POS_W-1:0];
        end
        else
        begin
            ans.status = ST_MISSING;
        end
        return ans;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        table_answer_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < TABLE_SLOTS; i++)
            begin
                shadow_key[i] = '0;
                shadow_tag[i] = TAG_EMPTY;
            end
            pending_answers.delete();
            waiting = 0;
        end
        else
        begin
            // Compare the answer against the oldest prediction
            if (rsp_valid === 1'b1 && rsp_ready === 1'b1)
            begin
                checked++;
                if (pending_answers.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected answer status %0d position %0d",
                                              status, position));
                end
                else
                begin
                    want = pending_answers.pop_front();
                    if (status !== want.status)
                        report_mismatch($sformatf("status %0d, predicted %0d",
                                                  status, want.status));
                    if (position !== want.position)
                        report_mismatch($sformatf("position %0d, predicted %0d",
                                                  position, want.position));
                end
            end
            // Predict the answer to an accepted item; the unused code gets none
            if (req_valid === 1'b1 && req_ready === 1'b1 && opcode != OP_NONE)
                pending_answers.push_back(apply_request(opcode, key));
            waiting = pending_answers.size();
        end
    end

endmodule

FILE: tb/linear_probe_hash_table_top_tb.sv
`timescale 1ns / 100ps

module linear_probe_hash_table_top_tb;
    import lpht_pkg::*;

    localparam int SLOTS          = 16;
    localparam int STALL_LIMIT    = 5000;
    localparam int DRAIN_CYCLES   = 40;
    localparam int ITEMS_PER_PASS = 250;
    localparam int POOL_SIZE      = 12;

    logic                clk       = 1'b0;
    logic                rst_n     = 1'b0;
    logic                req_valid = 1'b0;
    logic                req_ready;
    logic [OPCODE_W-1:0] opcode    = OP_INSERT;
    logic [KEY_W-1:0]    key       = '0;
    logic                rsp_valid;
    logic                rsp_ready = 1'b0;
    logic [STATUS_W-1:0] status;
    logic [POS_W-1:0]    position;

    int mismatch_count;
    int pending_count;
    int answers_checked;

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int quiet_cycles = 0;
    int op_sent [4] = '{0, 0, 0, 0};
    logic [KEY_W-1:0] key_pool [POOL_SIZE];

    linear_probe_hash_table_top #(.TABLE_SLOTS(SLOTS)) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .opcode    (opcode),
        .key       (key),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .status    (status),
        .position  (position)
    );

    lpht_result_checker #(.TABLE_SLOTS(SLOTS)) u_result_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .req_valid       (req_valid),
        .req_ready       (req_ready),
        .opcode          (opcode),
        .key             (key),
        .rsp_valid       (rsp_valid),
        .rsp_ready       (rsp_ready),
        .status          (status),
        .position        (position),
        .mismatch_count  (mismatch_count),
        .pending_count   (pending_count),
        .answers_checked (answers_checked)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Stall the response channel at random
    always @(posedge clk)
    begin
        rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // End the run if nothing is accepted for too long
    always @(posedge clk)
    begin
        if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("watchdog: no progress for %0d cycles", STALL_LIMIT);
            $display("linear_probe_hash_table_top_tb: errors");
            $finish;
        end
    end

    // Hold the request channel idle at random before the next item
    task automatic sender_gap();
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
    endtask

    // Present one item and hold it until accepted
    task automatic send_request(input logic [OPCODE_W-1:0] op, input logic [KEY_W-1:0] k);
        sender_gap();
        req_valid <= 1'b1;
        opcode    <= op;
        key       <= k;
        do @(posedge clk); while (req_ready !== 1'b1);
        op_sent[op]++;
    endtask

    // Refill the pool with keys that crowd a few home slots
    task automatic refresh_pool();
        for (int i = 0; i < POOL_SIZE; i++)
        begin
            key_pool[i] = KEY_W'($urandom);
            if (i < 9)
                key_pool[i][3:0] = 4'($urandom_range(3));
        end
        key_pool[POOL_SIZE-1] = {KEY_W{1'b1}};
    endtask

    function automatic logic [KEY_W-1:0] pick_key();
        if ($urandom_range(99) < 70)
            return key_pool[$urandom_range(POOL_SIZE-1)];
        if ($urandom_range(1) == 1)
            return KEY_W'($urandom);
        return KEY_W'($urandom_range(63));
    endfunction

    function automatic logic [OPCODE_W-1:0] pick_op();
        int r;
        r = $urandom_range(99);
        if (r < 36)
            return OP_INSERT;
        if (r < 62)
            return OP_SEARCH;
        if (r < 95)
            return OP_DELETE;
        return OP_NONE;
    endfunction

    initial
    begin
        int send_pct [4];
        int recv_pct [4];
        send_pct = '{0, 75, 0, 10};
        recv_pct = '{0, 0, 75, 10};

        // Reset once, then wait on the handshake for the clearing pass
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Extremes of the key, an insert and a search, the unused code
        send_request(OP_INSERT, '0);
        send_request(OP_INSERT, {KEY_W{1'b1}});
        send_request(OP_SEARCH, {KEY_W{1'b1}});
        send_request(OP_NONE, 31'd5);
        // Collisions on home slot zero, then a tombstone in the chain
        send_request(OP_INSERT, 31'd16);
        send_request(OP_INSERT, 31'd32);
        send_request(OP_DELETE, 31'd16);
        send_request(OP_SEARCH, 31'd32);
        send_request(OP_SEARCH, 31'd16);
        send_request(OP_INSERT, 31'd48);
        send_request(OP_DELETE, 31'd5);
        // Fill the remaining slots, overflow, then search a full table
        for (int k = 3; k <= 14; k++)
            send_request(OP_INSERT, KEY_W'(k));
        send_request(OP_INSERT, 31'd100);
        send_request(OP_SEARCH, 31'h7FFF_FFF0);

        // Random traffic under each pressure setting
        for (int p = 0; p < 4; p++)
        begin
            send_idle_pct  = send_pct[p];
            recv_stall_pct = recv_pct[p];
            refresh_pool();
            for (int i = 0; i < ITEMS_PER_PASS; i++)
                send_request(pick_op(), pick_key());
        end
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        req_valid <= 1'b0;

        // Drain outstanding answers, then watch for strays
        while (pending_count != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("sent %0d inserts, %0d searches, %0d deletes, %0d unused codes",
                 op_sent[OP_INSERT], op_sent[OP_SEARCH], op_sent[OP_DELETE],
                 op_sent[OP_NONE]);
        $display("checked %0d answers over four sender/receiver pressure phases",
                 answers_checked);
        if (mismatch_count == 0 && pending_count == 0)
            $display("linear_probe_hash_table_top_tb: clean");
        else
            $display("linear_probe_hash_table_top_tb: errors");
        $finish;
    end

endmodule

FILE: linear_probe_hash_table_top.f
rtl/lpht_pkg.sv
rtl/lpht_ram.sv
rtl/lpht_mod.sv
rtl/linear_probe_hash_table_top.sv
tb/lpht_result_checker.sv
tb/linear_probe_hash_table_top_tb.sv
